// ----- rtl/assert_macros.svh -----
// Assertion helpers for the tempo table checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define STET_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("tempo table check failed");

// Check an implication whose consequent must hold in the cycle after its antecedent.
`define STET_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tempo table sequence check failed");

`endif

// ----- rtl/stet_pkg.sv -----
`default_nettype none
package stet_pkg;

   localparam int unsigned MAX_RESULTS = 32;

   localparam logic [2:0]  REQ_SET    = 3'd0;
   localparam logic [2:0]  REQ_REMOVE = 3'd1;
   localparam logic [2:0]  REQ_CLEAR  = 3'd2;
   localparam logic [2:0]  REQ_FIND   = 3'd3;
   localparam logic [2:0]  REQ_RANGE  = 3'd4;

   localparam logic [25:0] RESET_BPM  = 26'd7864320;
   localparam logic [7:0]  NEW_BEATS  = 8'd4;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [63:0] position;
      logic [63:0] end_position;
      logic [25:0] tempo_bpm;
      logic [5:0]  max_events;
   } req_type;

   typedef struct packed {
      logic        status;
      logic        found;
      logic [63:0] out_position;
      logic [25:0] out_bpm;
      logic [7:0]  out_beats;
      logic        is_last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] position;
      logic [25:0] bpm;
      logic [7:0]  beats;
   } entry_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT,
      OP_ACCEPT,
      OP_READ_SCAN,
      OP_SCAN_NEXT,
      OP_FIND_TAKE,
      OP_STOP,
      OP_RANGE_PUT,
      OP_FINISH,
      OP_SHR_READ,
      OP_SHR_PLACE,
      OP_SHW,
      OP_SLR_READ,
      OP_SLW,
      OP_SL_DONE
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_RD,
      ST_CHK,
      ST_RPUT,
      ST_END,
      ST_SHR,
      ST_SHW,
      ST_SLR,
      ST_SLW
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       scan_done;
      logic       stop_hit;
      logic       find_take;
      logic       range_hit;
      logic       rsp_free;
      logic       pend_valid;
      logic       need_emit;
      logic       shift_r;
      logic       shift_l;
      logic       shr_at;
      logic       sl_last;
   } stat_type;

endpackage
`default_nettype wire

// ----- rtl/stet_ctrl.sv -----
`default_nettype none
module stet_ctrl
   import stet_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [2:0] req_kind,
   output logic            req_ready,
   input  wire stat_type   stat,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind) inside
                  REQ_SET, REQ_REMOVE, REQ_FIND, REQ_RANGE: state_in = ST_RD;
                  REQ_CLEAR: state_in = ST_END;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD: state_in = stat.scan_done ? ST_END : ST_CHK;
         ST_CHK: begin
            case (stat.kind) inside
               REQ_SET, REQ_REMOVE: state_in = stat.stop_hit ? ST_END : ST_RD;
               REQ_RANGE: state_in = stat.range_hit ? ST_RPUT : ST_RD;
               default: state_in = ST_RD;
            endcase
         end
         ST_RPUT: begin
            if (!(stat.pend_valid && !stat.rsp_free)) state_in = ST_RD;
         end
         ST_END: begin
            if (!(stat.need_emit && !stat.rsp_free)) begin
               if (stat.shift_r) state_in = ST_SHR;
               else if (stat.shift_l) state_in = ST_SLR;
               else state_in = ST_IDLE;
            end
         end
         ST_SHR: state_in = stat.shr_at ? ST_IDLE : ST_SHW;
         ST_SHW: state_in = ST_SHR;
         ST_SLR: state_in = stat.sl_last ? ST_IDLE : ST_SLW;
         ST_SLW: state_in = ST_SLR;
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      unique case (state_ff)
         ST_INIT: cmd.op = OP_INIT;
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_ACCEPT;
         end
         ST_RD: begin
            if (!stat.scan_done) cmd.op = OP_READ_SCAN;
         end
         ST_CHK: begin
            case (stat.kind) inside
               REQ_SET, REQ_REMOVE: cmd.op = stat.stop_hit ? OP_STOP : OP_SCAN_NEXT;
               REQ_FIND: cmd.op = stat.find_take ? OP_FIND_TAKE : OP_SCAN_NEXT;
               REQ_RANGE: cmd.op = stat.range_hit ? OP_NONE : OP_SCAN_NEXT;
               default: cmd.op = OP_SCAN_NEXT;
            endcase
         end
         ST_RPUT: begin
            if (!(stat.pend_valid && !stat.rsp_free)) cmd.op = OP_RANGE_PUT;
         end
         ST_END: begin
            if (!(stat.need_emit && !stat.rsp_free)) cmd.op = OP_FINISH;
         end
         ST_SHR: cmd.op = stat.shr_at ? OP_SHR_PLACE : OP_SHR_READ;
         ST_SHW: cmd.op = OP_SHW;
         ST_SLR: cmd.op = stat.sl_last ? OP_SL_DONE : OP_SLR_READ;
         ST_SLW: cmd.op = OP_SLW;
         default: cmd.op = OP_NONE;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/stet_dpath.sv -----
`default_nettype none
module stet_dpath
   import stet_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire req_type     req_payload,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output rsp_type          rsp_payload,
   input  wire logic        csr_valid,
   input  wire logic [25:0] csr_data
);

   localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_ff;

   logic [25:0]   default_bpm_ff;
   req_type       req_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] sidx_ff, sidx_in;
   logic [5:0]    n_ff, n_in;
   logic [5:0]    lim_ff, lim_in;
   logic          eq_ff, eq_in;
   entry_type     cand_ff, cand_in;
   entry_type     pend_ff, pend_in;
   logic          pend_valid_ff, pend_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          mem_we, mem_re;
   logic [IW-1:0] mem_wa, mem_ra;
   entry_type     mem_wd;
   logic          rsp_load;
   rsp_type       rsp_load_data;
   logic [CW-1:0] sidx_dec, sidx_inc;
   logic          rsp_free, rm_hit;

   assign sidx_dec = sidx_ff - CW'(1);
   assign sidx_inc = sidx_ff + CW'(1);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign rm_hit   = eq_ff && (req_ff.position != 64'd0);

   always_comb begin
      stat.kind       = req_ff.req_type;
      stat.scan_done  = (idx_ff == count_ff) ||
                        ((req_ff.req_type == REQ_RANGE) && (n_ff == lim_ff));
      stat.stop_hit   = rd_ff.position >= req_ff.position;
      stat.find_take  = (idx_ff == '0) || (rd_ff.position <= req_ff.position);
      stat.range_hit  = (rd_ff.position >= req_ff.position) &&
                        (rd_ff.position <= req_ff.end_position) && (n_ff < lim_ff);
      stat.rsp_free   = rsp_free;
      stat.pend_valid = pend_valid_ff;
      stat.need_emit  = !((req_ff.req_type == REQ_RANGE) && !pend_valid_ff);
      stat.shift_r    = (req_ff.req_type == REQ_SET) && !eq_ff && (count_ff != DEPTH_C);
      stat.shift_l    = (req_ff.req_type == REQ_REMOVE) && rm_hit;
      stat.shr_at     = sidx_ff == idx_ff;
      stat.sl_last    = sidx_inc == count_ff;
   end

   always_comb begin
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      mem_re        = 1'b0;
      mem_ra        = '0;
      rsp_load      = 1'b0;
      rsp_load_data = '0;
      count_in      = count_ff;
      idx_in        = idx_ff;
      sidx_in       = sidx_ff;
      n_in          = n_ff;
      lim_in        = lim_ff;
      eq_in         = eq_ff;
      cand_in       = cand_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      case (cmd.op)
         OP_INIT: begin
            mem_we   = 1'b1;
            mem_wd   = '{position: 64'd0, bpm: default_bpm_ff, beats: NEW_BEATS};
            count_in = CW'(1);
         end
         OP_ACCEPT: begin
            idx_in        = '0;
            n_in          = '0;
            lim_in        = (req_payload.max_events > 6'(MAX_RESULTS)) ?
                            6'(MAX_RESULTS) : req_payload.max_events;
            eq_in         = 1'b0;
            pend_valid_in = 1'b0;
         end
         OP_READ_SCAN: begin
            mem_re = 1'b1;
            mem_ra = idx_ff[IW-1:0];
         end
         OP_SCAN_NEXT: idx_in = idx_ff + CW'(1);
         OP_FIND_TAKE: begin
            cand_in = rd_ff;
            idx_in  = idx_ff + CW'(1);
         end
         OP_STOP: eq_in = rd_ff.position == req_ff.position;
         OP_RANGE_PUT: begin
            if (pend_valid_ff) begin
               rsp_load      = 1'b1;
               rsp_load_data = '{status: 1'b0, found: 1'b1, out_position: pend_ff.position,
                                 out_bpm: pend_ff.bpm, out_beats: pend_ff.beats,
                                 is_last: 1'b0};
            end
            pend_in       = rd_ff;
            pend_valid_in = 1'b1;
            n_in          = n_ff + 6'd1;
            idx_in        = idx_ff + CW'(1);
         end
         OP_FINISH: begin
            rsp_load_data.is_last = 1'b1;
            case (req_ff.req_type)
               REQ_SET: begin
                  rsp_load = 1'b1;
                  if (eq_ff) begin
                     mem_we = 1'b1;
                     mem_wa = idx_ff[IW-1:0];
                     mem_wd = '{position: req_ff.position, bpm: req_ff.tempo_bpm,
                                beats: rd_ff.beats};
                     rsp_load_data.found        = 1'b1;
                     rsp_load_data.out_position = req_ff.position;
                     rsp_load_data.out_bpm      = req_ff.tempo_bpm;
                     rsp_load_data.out_beats    = rd_ff.beats;
                  end else if (count_ff == DEPTH_C) begin
                     rsp_load_data.status = 1'b1;
                  end else begin
                     sidx_in                    = count_ff;
                     rsp_load_data.found        = 1'b1;
                     rsp_load_data.out_position = req_ff.position;
                     rsp_load_data.out_bpm      = req_ff.tempo_bpm;
                     rsp_load_data.out_beats    = NEW_BEATS;
                  end
               end
               REQ_REMOVE: begin
                  rsp_load = 1'b1;
                  if (rm_hit) begin
                     sidx_in                    = idx_ff;
                     rsp_load_data.found        = 1'b1;
                     rsp_load_data.out_position = rd_ff.position;
                     rsp_load_data.out_bpm      = rd_ff.bpm;
                     rsp_load_data.out_beats    = rd_ff.beats;
                  end
               end
               REQ_CLEAR: begin
                  rsp_load = 1'b1;
                  mem_we   = 1'b1;
                  mem_wd   = '{position: 64'd0, bpm: default_bpm_ff, beats: NEW_BEATS};
                  count_in = CW'(1);
                  rsp_load_data.found     = 1'b1;
                  rsp_load_data.out_bpm   = default_bpm_ff;
                  rsp_load_data.out_beats = NEW_BEATS;
               end
               REQ_FIND: begin
                  rsp_load = 1'b1;
                  if (count_ff == '0) begin
                     rsp_load_data.out_bpm   = default_bpm_ff;
                     rsp_load_data.out_beats = NEW_BEATS;
                  end else begin
                     rsp_load_data.found        = 1'b1;
                     rsp_load_data.out_position = cand_ff.position;
                     rsp_load_data.out_bpm      = cand_ff.bpm;
                     rsp_load_data.out_beats    = cand_ff.beats;
                  end
               end
               REQ_RANGE: begin
                  rsp_load                   = pend_valid_ff;
                  rsp_load_data.found        = 1'b1;
                  rsp_load_data.out_position = pend_ff.position;
                  rsp_load_data.out_bpm      = pend_ff.bpm;
                  rsp_load_data.out_beats    = pend_ff.beats;
               end
               default: rsp_load = 1'b0;
            endcase
         end
         OP_SHR_READ: begin
            mem_re = 1'b1;
            mem_ra = sidx_dec[IW-1:0];
         end
         OP_SHR_PLACE: begin
            mem_we   = 1'b1;
            mem_wa   = idx_ff[IW-1:0];
            mem_wd   = '{position: req_ff.position, bpm: req_ff.tempo_bpm, beats: NEW_BEATS};
            count_in = count_ff + CW'(1);
         end
         OP_SHW: begin
            mem_we  = 1'b1;
            mem_wa  = sidx_ff[IW-1:0];
            mem_wd  = rd_ff;
            sidx_in = sidx_dec;
         end
         OP_SLR_READ: begin
            mem_re = 1'b1;
            mem_ra = sidx_inc[IW-1:0];
         end
         OP_SLW: begin
            mem_we  = 1'b1;
            mem_wa  = sidx_ff[IW-1:0];
            mem_wd  = rd_ff;
            sidx_in = sidx_inc;
         end
         OP_SL_DONE: count_in = count_ff - CW'(1);
         default: mem_we = 1'b0;
      endcase
   end

   assign rsp_in       = rsp_load ? rsp_load_data : rsp_ff;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_bpm_ff <= RESET_BPM;
         count_ff       <= CW'(1);
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         idx_ff         <= '0;
         sidx_ff        <= '0;
         n_ff           <= '0;
         lim_ff         <= '0;
         eq_ff          <= 1'b0;
      end else begin
         if (csr_valid) default_bpm_ff <= csr_data;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         sidx_ff       <= sidx_in;
         n_ff          <= n_in;
         lim_ff        <= lim_in;
         eq_ff         <= eq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT) req_ff <= req_payload;
      cand_ff <= cand_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/sorted_tempo_event_table_top.sv -----
// Sorted tempo table: entries live in a single-port memory with registered
// reads, so set, remove and find walk the table with a read state and a check
// state per entry visited, and an insert or delete moves each following entry
// with a read state and a write state. An unknown request is taken and gives
// no result; a new request is taken only after the last is done, and a stall
// of the result channel holds a request. Range results leave one beat at a
// time through an output register. After reset the INIT state writes the
// default entry before the first request is taken. Configuration is always
// ready.
`default_nettype none
module sorted_tempo_event_table_top
   import stet_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_payload,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [25:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   stet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.req_type),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   stet_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid && csr_ready),
      .csr_data    (csr_data)
   );

endmodule
`default_nettype wire

// ----- rtl/stet_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module stet_checker
   import stet_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire req_type     req_payload,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire rsp_type     rsp_payload,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [25:0] csr_data
);

   logic known_req;
   logic full_shape_ok;
   assign known_req = (req_payload.req_type == REQ_SET) ||
                      (req_payload.req_type == REQ_REMOVE) ||
                      (req_payload.req_type == REQ_CLEAR) ||
                      (req_payload.req_type == REQ_FIND) ||
                      (req_payload.req_type == REQ_RANGE);
   assign full_shape_ok = !rsp_payload.status ||
                          (!rsp_payload.found && rsp_payload.is_last);

   `STET_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `STET_ASSERT(a_full_shape, !rsp_valid || full_shape_ok)
   `STET_ASSERT(a_miss_is_last, !(rsp_valid && !rsp_payload.found) || rsp_payload.is_last)
   `STET_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready && known_req, !req_ready)
   `STET_ASSERT(a_csr_known, !(csr_valid && csr_ready) || !$isunknown(csr_data))

endmodule

bind sorted_tempo_event_table_top stet_checker u_stet_checker (.*);
`default_nettype wire

// ----- tb/sv/stet_checker.sv -----
`default_nettype none
module stet_scoreboard
   import stet_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire req_type     req_payload,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire rsp_type     rsp_payload,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [25:0] csr_data,
   output int               fail_count,
   output int               pending
);

   logic [63:0] tbl_pos [TABLE_DEPTH];
   logic [25:0] tbl_bpm [TABLE_DEPTH];
   logic [7:0]  tbl_beats [TABLE_DEPTH];
   int unsigned tbl_count;
   logic [25:0] base_bpm;
   rsp_type     tempo_rsps [$];

   function automatic rsp_type make_rsp(logic st, logic fnd, logic [63:0] pos,
                                        logic [25:0] bpm, logic [7:0] beats,
                                        logic last);
      rsp_type r;
      r.status = st;
      r.found = fnd;
      r.out_position = pos;
      r.out_bpm = bpm;
      r.out_beats = beats;
      r.is_last = last;
      return r;
   endfunction

   task automatic queue_rsp(rsp_type r);
      tempo_rsps.insert(tempo_rsps.size(), r);
   endtask

   task automatic load_default_entry();
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         tbl_pos[k] = '0;
         tbl_bpm[k] = '0;
         tbl_beats[k] = '0;
      end
      tbl_bpm[0] = base_bpm;
      tbl_beats[0] = NEW_BEATS;
      tbl_count = 1;
   endtask

   task automatic predict_table_op(req_type r);
      int unsigned hit;
      int unsigned slot;
      int unsigned limit;
      int          n;
      hit = tbl_count;
      for (int k = 0; k < tbl_count; k++)
         if (hit == tbl_count && tbl_pos[k] == r.position) hit = k;
      case (r.req_type)
         REQ_SET: begin
            if (hit < tbl_count) begin
               tbl_bpm[hit] = r.tempo_bpm;
               queue_rsp(make_rsp(1'b0, 1'b1, r.position, r.tempo_bpm,
                                  tbl_beats[hit], 1'b1));
            end else if (tbl_count >= TABLE_DEPTH) begin
               queue_rsp(make_rsp(1'b1, 1'b0, '0, '0, '0, 1'b1));
            end else begin
               slot = 0;
               while (slot < tbl_count && tbl_pos[slot] < r.position) slot++;
               for (int k = tbl_count; k > slot; k--) begin
                  tbl_pos[k] = tbl_pos[k-1];
                  tbl_bpm[k] = tbl_bpm[k-1];
                  tbl_beats[k] = tbl_beats[k-1];
               end
               tbl_pos[slot] = r.position;
               tbl_bpm[slot] = r.tempo_bpm;
               tbl_beats[slot] = NEW_BEATS;
               tbl_count++;
               queue_rsp(make_rsp(1'b0, 1'b1, r.position, r.tempo_bpm,
                                  NEW_BEATS, 1'b1));
            end
         end
         REQ_REMOVE: begin
            if (r.position == 0 || hit >= tbl_count) begin
               queue_rsp(make_rsp(1'b0, 1'b0, '0, '0, '0, 1'b1));
            end else begin
               queue_rsp(make_rsp(1'b0, 1'b1, tbl_pos[hit], tbl_bpm[hit],
                                  tbl_beats[hit], 1'b1));
               for (int k = hit; k + 1 < tbl_count; k++) begin
                  tbl_pos[k] = tbl_pos[k+1];
                  tbl_bpm[k] = tbl_bpm[k+1];
                  tbl_beats[k] = tbl_beats[k+1];
               end
               tbl_count--;
               tbl_pos[tbl_count] = '0;
               tbl_bpm[tbl_count] = '0;
               tbl_beats[tbl_count] = '0;
            end
         end
         REQ_CLEAR: begin
            load_default_entry();
            queue_rsp(make_rsp(1'b0, 1'b1, '0, base_bpm, NEW_BEATS, 1'b1));
         end
         REQ_FIND: begin
            if (tbl_count == 0) begin
               queue_rsp(make_rsp(1'b0, 1'b0, '0, base_bpm, NEW_BEATS, 1'b1));
            end else begin
               slot = 0;
               for (int k = 1; k < tbl_count; k++)
                  if (tbl_pos[k] <= r.position) slot = k;
               queue_rsp(make_rsp(1'b0, 1'b1, tbl_pos[slot], tbl_bpm[slot],
                                  tbl_beats[slot], 1'b1));
            end
         end
         REQ_RANGE: begin
            limit = (r.max_events > MAX_RESULTS) ? MAX_RESULTS : r.max_events;
            n = 0;
            for (int k = 0; k < tbl_count && n < limit; k++) begin
               if (tbl_pos[k] >= r.position && tbl_pos[k] <= r.end_position) begin
                  queue_rsp(make_rsp(1'b0, 1'b1, tbl_pos[k], tbl_bpm[k],
                                     tbl_beats[k], 1'b0));
                  n++;
               end
            end
            if (n > 0) tempo_rsps[tempo_rsps.size()-1].is_last = 1'b1;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         fail_count = 0;
         base_bpm = RESET_BPM;
         load_default_entry();
         tempo_rsps.delete();
      end else begin
         if (csr_valid && csr_ready) base_bpm = csr_data;
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (tempo_rsps.size() == 0) begin
               $error("unexpected result beat: position %0h", got.out_position);
               fail_count++;
            end else begin
               want = tempo_rsps.pop_front();
               if (got.status !== want.status) begin
                  $error("status expected %0h actual %0h", want.status, got.status);
                  fail_count++;
               end
               if (got.found !== want.found) begin
                  $error("found expected %0h actual %0h", want.found, got.found);
                  fail_count++;
               end
               if (got.out_position !== want.out_position) begin
                  $error("out_position expected %0h actual %0h",
                         want.out_position, got.out_position);
                  fail_count++;
               end
               if (got.out_bpm !== want.out_bpm) begin
                  $error("out_bpm expected %0h actual %0h", want.out_bpm, got.out_bpm);
                  fail_count++;
               end
               if (got.out_beats !== want.out_beats) begin
                  $error("out_beats expected %0h actual %0h",
                         want.out_beats, got.out_beats);
                  fail_count++;
               end
               if (got.is_last !== want.is_last) begin
                  $error("is_last expected %0h actual %0h", want.is_last, got.is_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) predict_table_op(req_payload);
      end
      pending <= tempo_rsps.size();
   end

endmodule
`default_nettype wire

// ----- tb/sv/sorted_tempo_event_table_top_tb.sv -----
`default_nettype none
module sorted_tempo_event_table_top_tb;
   import stet_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [63:0] POS_MAX = '1;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_payload;
   logic        csr_valid;
   logic        csr_ready;
   logic [25:0] csr_data;
   int          fail_count;
   int          pending;
   int          cycles = 0;
   bit          send_idle = 1'b1;
   bit          recv_idle = 1'b1;
   int          hold_request = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sorted_tempo_event_table_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   stet_scoreboard checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** sorted_tempo_event_table_top: FAILED **");
         $finish;
      end
   end

   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0 && !hold_done) begin
            hold_left = hold_request;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= !(recv_idle && $urandom_range(99) < 27);
         end
      end
   end

   function automatic req_type make_req(logic [2:0] kind, logic [63:0] pos,
                                        logic [63:0] endp, logic [25:0] bpm,
                                        logic [5:0] maxe);
      req_type r;
      r.req_type = kind;
      r.position = pos;
      r.end_position = endp;
      r.tempo_bpm = bpm;
      r.max_events = maxe;
      return r;
   endfunction

   function automatic logic [63:0] pick_position();
      int sel;
      sel = $urandom_range(99);
      if (sel < 75) return 64'($urandom_range(40)) * 64'd1000;
      if (sel < 92) return {$urandom, $urandom};
      return (sel < 96) ? 64'd0 : POS_MAX;
   endfunction

   function automatic req_type random_req(int set_pct);
      int          sel;
      logic [2:0]  kind;
      logic [63:0] pos;
      logic [63:0] endp;
      sel = $urandom_range(99);
      if (sel < set_pct) kind = REQ_SET;
      else if (sel < set_pct + (100 - set_pct) * 25 / 100) kind = REQ_REMOVE;
      else if (sel < set_pct + (100 - set_pct) * 55 / 100) kind = REQ_FIND;
      else if (sel < set_pct + (100 - set_pct) * 90 / 100) kind = REQ_RANGE;
      else if (sel < set_pct + (100 - set_pct) * 95 / 100) kind = REQ_CLEAR;
      else kind = 3'($urandom_range(7, 5));
      pos = pick_position();
      case ($urandom_range(3))
         0: endp = {$urandom, $urandom};
         1: endp = POS_MAX;
         default: endp = pos + 64'($urandom_range(40000));
      endcase
      return make_req(kind, pos, endp, 26'($urandom), 6'($urandom));
   endfunction

   task automatic send_req(req_type r);
      while (send_idle && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_default_bpm(logic [25:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_default_bpm(26'd0);
      send_req(make_req(REQ_FIND, POS_MAX, '0, '0, '0));
      send_req(make_req(REQ_CLEAR, '0, '0, '0, '0));
      send_req(make_req(REQ_SET, POS_MAX, '0, 26'h3FFFFFF, '0));
      send_req(make_req(REQ_SET, 64'd1, '0, 26'd0, 6'h3F));
      send_req(make_req(REQ_SET, 64'h8000_0000_0000_0000, POS_MAX, 26'h2AAAAAA, '0));
      send_req(make_req(REQ_SET, 64'd0, '0, 26'h1555555, '0));
      send_req(make_req(REQ_FIND, 64'd0, '0, '0, '0));
      send_req(make_req(REQ_FIND, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, '0));
      send_req(make_req(REQ_FIND, POS_MAX, '0, '0, '0));
      send_req(make_req(REQ_RANGE, 64'd0, POS_MAX, '0, 6'd32));
      send_req(make_req(REQ_RANGE, 64'd0, POS_MAX, '0, 6'd0));
      send_req(make_req(REQ_RANGE, 64'd5, 64'd4, '0, 6'd32));
      send_req(make_req(REQ_RANGE, 64'd2, 64'd3, '0, 6'd32));
      send_req(make_req(REQ_RANGE, 64'd0, POS_MAX, '0, 6'h3F));
      send_req(make_req(REQ_RANGE, 64'd1, POS_MAX, '0, 6'd2));
      send_req(make_req(REQ_REMOVE, 64'd0, '0, '0, '0));
      send_req(make_req(REQ_REMOVE, 64'd77, '0, '0, '0));
      send_req(make_req(REQ_REMOVE, 64'd1, '0, '0, '0));
      send_req(make_req(3'd5, 64'd1, POS_MAX, 26'h3FFFFFF, 6'd32));
      send_req(make_req(3'd7, POS_MAX, POS_MAX, 26'h3FFFFFF, 6'h3F));
      send_req(make_req(REQ_FIND, 64'd1, '0, '0, '0));
      wait_drained();

      write_default_bpm(26'h3FFFFFF);
      send_req(make_req(REQ_CLEAR, '0, '0, '0, '0));
      for (int k = 0; k < 110; k++) send_req(random_req(35));
      wait_drained();

      write_default_bpm(26'($urandom));
      for (int k = 0; k < 110; k++) send_req(random_req(80));
      send_req(make_req(REQ_SET, 64'd123456789, '0, 26'd9, '0));
      wait_drained();

      write_default_bpm(RESET_BPM);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      for (int k = 0; k < 40; k++) send_req(random_req(50));
      hold_request = 600;
      for (int k = 0; k < 20; k++)
         send_req(make_req(REQ_RANGE, 64'd0, POS_MAX, '0, 6'd32));
      send_idle = 1'b1;
      recv_idle = 1'b1;
      wait_drained();
      for (int k = 0; k < 30; k++) send_req(random_req(40));
      wait_drained();

      if (fail_count == 0) begin
         $display("** sorted_tempo_event_table_top: PASSED **");
      end else begin
         $display("** sorted_tempo_event_table_top: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire
